// ===== src/assert_macros.svh =====
// assertion macros shared by the ring buffer rtl
// expects clk_i and rst_ni in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every clock edge out of reset
`define OBRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication
`define OBRB_ASSERT_IMP(lbl, ante, cons, msg) \
  `OBRB_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define OBRB_ASSERT_NXT(lbl, ante, cons, msg) \
  `OBRB_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== src/obrb_pkg.sv =====
// package for the overwriting byte ring buffer
// field widths, opcodes, status codes and parameter defaults; no dependencies
package obrb_pkg;

  localparam int CAP_W  = 9;
  localparam int AMT_W  = 9;
  localparam int OFF_W  = 8;
  localparam int DATA_W = 64;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  localparam int DEPTH_DEF      = 256;
  localparam int MAX_ACCESS_DEF = 8;

  localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
  localparam logic [OP_W-1:0] OP_READ   = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
  localparam logic [OP_W-1:0] OP_REWIND = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_SHORT = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

endpackage

// ===== src/obrb_ram.sv =====
// generic single-port ram with registered read data
// no package dependencies
module obrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/obrb_wrap.sv =====
// shared modular adder: (a + b) mod cap, valid while a + b < 2 * cap
// no package dependencies
module obrb_wrap #(
  parameter int W = 10
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] cap_i,
  output logic [W-1:0] sum_o
);

  logic [W:0] raw;

  always_comb begin
    raw = {1'b0, a_i} + {1'b0, b_i};
    if (raw >= {1'b0, cap_i}) begin
      raw = raw - {1'b0, cap_i};
    end
    sum_o = raw[W-1:0];
  end

endmodule

// ===== src/overwriting_byte_ring_buffer.sv =====
// top level of the overwriting byte ring buffer: sequencer, pointers, result registers
// depends on obrb_pkg, obrb_ram, obrb_wrap and assert_macros.svh
//
//  channel   direction  handshake                  payload
//  command   in         start / busy               opcode, amount, peek_offset, big_endian, value
//  result    out        done_o strobe, no stall    read_data, status, used_bytes, flags
//  config    in         cfg_valid_i / cfg_ready_o  capacity
//
// a command is taken when start is high and busy is low; busy stays high until its result
// a write runs check, a write state per byte and done; a read or peek check, a read state per byte,
// drain and done; other commands check and done; one byte per cycle through the single store port
// and the one wrap adder; the result strobe lasts one cycle and the receiver cannot hold it off
// reset leaves capacity at the store depth and the buffer empty; the store itself is not cleared
// a capacity write also empties the buffer and is only taken while busy is low
`include "assert_macros.svh"

module overwriting_byte_ring_buffer #(
  parameter int DEPTH            = obrb_pkg::DEPTH_DEF,
  parameter int MAX_ACCESS_BYTES = obrb_pkg::MAX_ACCESS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command
  input  logic                        start,
  output logic                        busy,
  input  logic [obrb_pkg::OP_W-1:0]   opcode_i,
  input  logic [obrb_pkg::AMT_W-1:0]  amount_i,
  input  logic [obrb_pkg::OFF_W-1:0]  peek_offset_i,
  input  logic                        big_endian_i,
  input  logic [obrb_pkg::DATA_W-1:0] value_i,
  // result
  output logic                        done_o,
  output logic [obrb_pkg::DATA_W-1:0] read_data_o,
  output logic [obrb_pkg::ST_W-1:0]   status_o,
  output logic [obrb_pkg::CAP_W-1:0]  used_bytes_o,
  output logic                        is_full_o,
  output logic                        is_empty_o,
  output logic                        overwrote_o,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [obrb_pkg::CAP_W-1:0]  cfg_data_i
);

  import obrb_pkg::*;

  // pointer width, and a working width that holds capacity, pointers and their sums
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = (PW > CAP_W) ? PW : CAP_W;
  localparam int WW    = CW + 1;
  localparam int IDX_W = (MAX_ACCESS_BYTES > 1) ? $clog2(MAX_ACCESS_BYTES) : 1;

  localparam logic [WW-1:0]    DepthW = WW'(DEPTH);
  localparam logic [AMT_W-1:0] MaxAmt = AMT_W'(MAX_ACCESS_BYTES);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_WR    = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [CAP_W-1:0] free_q, free_d;
  logic [PW-1:0]    rp_q, rp_d;
  logic [PW-1:0]    wp_q, wp_d;
  logic [PW-1:0]    addr_q, addr_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [ST_W-1:0]  status_q, status_d;
  logic             over_q, over_d;
  logic             rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0] rd_sel_q;

  // command payload, held for the whole command
  logic [OP_W-1:0]   op_q;
  logic [AMT_W-1:0]  amt_q;
  logic [OFF_W-1:0]  off_q;
  logic              big_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] data_q;

  logic              take_cmd;
  logic              take_cfg;
  logic [CAP_W-1:0]  cap_clamp;
  logic [CAP_W-1:0]  used;
  logic [CAP_W:0]    need;
  logic              amt_bad;
  logic [IDX_W-1:0]  sel;
  logic              last_byte;

  // shared wrap adder
  logic [WW-1:0] wa, wb, wsum;

  // store port
  logic          ram_we;
  logic [7:0]    ram_rdata;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = !busy;
  assign take_cmd    = start && !busy;
  assign take_cfg    = cfg_valid_i && cfg_ready_o;

  // capacity 0 acts as 1, anything above the store depth as the depth
  always_comb begin
    if (cfg_data_i == '0) begin
      cap_clamp = CAP_W'(1);
    end else if (WW'(cfg_data_i) > DepthW) begin
      cap_clamp = DepthW[CAP_W-1:0];
    end else begin
      cap_clamp = cfg_data_i;
    end
  end

  assign used    = cap_q - free_q;
  assign amt_bad = (amt_q == '0) || (amt_q > MaxAmt);
  // a read starts at the oldest byte, a peek further in
  assign need    = {1'b0, amt_q} + ((op_q == OP_PEEK) ? (CAP_W+1)'(off_q) : '0);

  // byte lane of the current step, first stored byte is the msb lane when big endian
  assign sel       = big_q ? (amt_q[IDX_W-1:0] - IDX_W'(1) - cnt_q) : cnt_q;
  assign last_byte = (cnt_q == amt_q[IDX_W-1:0] - IDX_W'(1));

  obrb_wrap #(.W(WW)) u_wrap (
    .a_i   (wa),
    .b_i   (wb),
    .cap_i (WW'(cap_q)),
    .sum_o (wsum)
  );

  assign ram_we = (state_q == S_WR);

  obrb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (addr_q),
    .wdata_i (val_q[8*sel +: 8]),
    .rdata_o (ram_rdata)
  );

  // wrap adder operand selection
  always_comb begin
    wa = WW'(addr_q);
    wb = WW'(1);
    if (state_q == S_CHECK) begin
      case (op_q)
        OP_WRITE: begin
          // bytes to drop from the old end when the write does not fit
          wa = WW'(rp_q);
          wb = WW'(amt_q) - WW'(free_q);
        end
        OP_PEEK: begin
          wa = WW'(rp_q);
          wb = WW'(off_q);
        end
        OP_ERASE: begin
          wa = WW'(rp_q);
          wb = WW'(amt_q);
        end
        OP_REWIND: begin
          wa = WW'(wp_q);
          wb = WW'(cap_q) - WW'(amt_q);
        end
        default: begin
          wa = WW'(rp_q);
          wb = '0;
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    cap_d     = cap_q;
    free_d    = free_q;
    rp_d      = rp_q;
    wp_d      = wp_q;
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    status_d  = status_q;
    over_d    = over_q;
    rd_pend_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (take_cfg) begin
          cap_d  = cap_clamp;
          free_d = cap_clamp;
          rp_d   = '0;
          wp_d   = '0;
        end
        if (take_cmd) begin
          status_d = ST_OK;
          over_d   = 1'b0;
          cnt_d    = '0;
          state_d  = S_CHECK;
        end
      end

      S_CHECK: begin
        state_d = S_DONE;
        case (op_q)
          OP_WRITE: begin
            if (amt_bad || (amt_q > cap_q)) begin
              status_d = ST_RANGE;
            end else begin
              if (free_q < amt_q) begin
                rp_d   = PW'(wsum);
                free_d = amt_q;
                over_d = 1'b1;
              end
              addr_d  = wp_q;
              state_d = S_WR;
            end
          end
          OP_READ, OP_PEEK: begin
            if (amt_bad) begin
              status_d = ST_RANGE;
            end else if (need > {1'b0, used}) begin
              status_d = ST_SHORT;
            end else begin
              addr_d  = PW'(wsum);
              state_d = S_RD;
            end
          end
          OP_ERASE: begin
            if (amt_q > used) begin
              status_d = ST_SHORT;
            end else begin
              rp_d   = PW'(wsum);
              free_d = free_q + amt_q;
            end
          end
          OP_REWIND: begin
            if (amt_q > used) begin
              status_d = ST_SHORT;
            end else begin
              wp_d   = PW'(wsum);
              free_d = free_q + amt_q;
            end
          end
          OP_CLEAR: begin
            rp_d   = '0;
            wp_d   = '0;
            free_d = cap_q;
          end
          default: begin
            status_d = ST_RANGE;
          end
        endcase
      end

      S_WR: begin
        // one store byte per cycle, the address walks through the adder
        addr_d = PW'(wsum);
        cnt_d  = cnt_q + IDX_W'(1);
        if (last_byte) begin
          wp_d    = PW'(wsum);
          free_d  = free_q - amt_q;
          state_d = S_DONE;
        end
      end

      S_RD: begin
        rd_pend_d = 1'b1;
        addr_d    = PW'(wsum);
        cnt_d     = cnt_q + IDX_W'(1);
        if (last_byte) begin
          state_d = S_DRAIN;
        end
      end

      S_DRAIN: begin
        // last byte lands this cycle; addr_q now sits one past the run
        if (op_q == OP_READ) begin
          rp_d   = addr_q;
          free_d = free_q + amt_q;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cap_q     <= DepthW[CAP_W-1:0];
      free_q    <= DepthW[CAP_W-1:0];
      rp_q      <= '0;
      wp_q      <= '0;
      addr_q    <= '0;
      cnt_q     <= '0;
      status_q  <= ST_OK;
      over_q    <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cap_q     <= cap_d;
      free_q    <= free_d;
      rp_q      <= rp_d;
      wp_q      <= wp_d;
      addr_q    <= addr_d;
      cnt_q     <= cnt_d;
      status_q  <= status_d;
      over_q    <= over_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take_cmd) begin
      op_q   <= opcode_i;
      amt_q  <= amount_i;
      off_q  <= peek_offset_i;
      big_q  <= big_endian_i;
      val_q  <= value_i;
      data_q <= '0;
    end else if (rd_pend_q) begin
      data_q[8*rd_sel_q +: 8] <= ram_rdata;
    end
    if (state_q == S_RD) begin
      rd_sel_q <= sel;
    end
  end

  // result ports
  assign done_o       = (state_q == S_DONE);
  assign read_data_o  = data_q;
  assign status_o     = status_q;
  assign used_bytes_o = used;
  assign is_full_o    = (free_q == '0);
  assign is_empty_o   = (used == '0);
  assign overwrote_o  = over_q;

  `OBRB_ASSERT(a_free_le_cap, free_q <= cap_q, "free count above capacity")
  `OBRB_ASSERT(a_rp_in_range, WW'(rp_q) < WW'(cap_q), "read pointer beyond capacity")
  `OBRB_ASSERT_NXT(a_cmd_busy, take_cmd, busy && !done_o, "accepted command not busy")
  `OBRB_ASSERT_IMP(a_over_full, done_o && overwrote_o, is_full_o && (status_o == ST_OK),
                   "overwriting write did not leave buffer full")
  `OBRB_ASSERT_NXT(a_done_single, done_o, !done_o && !busy, "result strobe longer than a cycle")

endmodule
